FILE: hdl/crse_pkg.sv
// Shared constants, codes and types of the Catmull-Rom spline evaluator.
// No dependencies; crse_cubic and catmull_rom_spline_eval use this package by scoped names.
package crse_pkg;

    localparam int MAX_POINTS = 256;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int IDX_W      = 9;
    localparam int PC_W       = 9;
    localparam int CMP_W      = ((CNT_W > IDX_W) ? CNT_W : IDX_W) + 1;

    localparam int COORD_W    = 32;
    localparam int TR_W       = 17;
    localparam int STEP_W     = 16;
    localparam int T_W        = 18;
    localparam int D_W        = COORD_W + 1;
    localparam int H_W        = 44;
    localparam int LO_W       = H_W / 2;
    localparam int MA_W       = LO_W + 1;
    localparam int MB_W       = T_W + 1;
    localparam int PR_W       = MA_W + MB_W;
    localparam int ACC_W      = 64;
    localparam int FRAC_W     = 16;

    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    localparam logic [STEP_W-1:0] STEP_RESET = 16'd655;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_EVAL  = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FEW  = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef enum logic {
        REG_LOOKAHEAD = 1'b0
    } t_reg;

    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_CSTART,
        S_CWAIT
    } t_state;

    typedef enum logic [1:0] {
        C_IDLE,
        C_COEF,
        C_MUL,
        C_FINAL
    } t_cub_state;

    typedef struct packed {
        logic           start;
        logic [T_W-1:0] t;
    } t_cub_req;

    typedef struct packed {
        logic               done;
        logic [COORD_W-1:0] value;
    } t_cub_rsp;

endpackage

FILE: hdl/crse_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module crse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/crse_cubic.sv
// One-axis Catmull-Rom cubic: coefficients, then Horner steps on one shared
// multiplier (two partial products per step). Depends on crse_pkg.
module crse_cubic (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  crse_pkg::t_cub_req                   i_req,
    input  logic signed [crse_pkg::COORD_W-1:0]  i_p0,
    input  logic signed [crse_pkg::COORD_W-1:0]  i_p1,
    input  logic signed [crse_pkg::COORD_W-1:0]  i_p2,
    input  logic signed [crse_pkg::COORD_W-1:0]  i_p3,
    output crse_pkg::t_cub_rsp                   o_rsp
);

    localparam logic signed [crse_pkg::H_W-1:0] SAT_HI =
        crse_pkg::H_W'(64'sd2147483647);
    localparam logic signed [crse_pkg::H_W-1:0] SAT_LO =
        crse_pkg::H_W'(-64'sd2147483648);
    localparam logic signed [crse_pkg::ACC_W-1:0] RND_HALF =
        crse_pkg::ACC_W'(64'sd1) <<< (crse_pkg::FRAC_W - 1);

    crse_pkg::t_cub_state r_state, n_state;

    logic signed [crse_pkg::D_W-1:0]   r_d, r_e, r_f;
    logic signed [crse_pkg::H_W-1:0]   r_c0, r_c1, r_c2, r_h;
    logic        [crse_pkg::T_W-1:0]   r_t;
    logic        [1:0]                 r_phase;
    logic        [1:0]                 r_step;
    logic signed [crse_pkg::PR_W-1:0]  r_prod;
    logic signed [crse_pkg::ACC_W-1:0] r_acc;
    logic signed [crse_pkg::COORD_W-1:0] r_val;
    logic                              r_done;

    logic signed [crse_pkg::MA_W-1:0]  mul_a;
    logic signed [crse_pkg::MB_W-1:0]  mul_b;
    logic signed [crse_pkg::PR_W-1:0]  mul_p;
    logic signed [crse_pkg::H_W-1:0]   c_sel;
    logic signed [crse_pkg::ACC_W-1:0] rnd;
    logic signed [crse_pkg::H_W-1:0]   h_next;
    logic signed [crse_pkg::H_W-1:0]   half;
    logic signed [crse_pkg::COORD_W-1:0] sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= crse_pkg::C_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            crse_pkg::C_IDLE: begin
                if (i_req.start) begin
                    n_state = crse_pkg::C_COEF;
                end
            end
            crse_pkg::C_COEF: begin
                n_state = crse_pkg::C_MUL;
            end
            crse_pkg::C_MUL: begin
                if (r_phase == 2'd3 && r_step == 2'd2) begin
                    n_state = crse_pkg::C_FINAL;
                end
            end
            crse_pkg::C_FINAL: begin
                n_state = crse_pkg::C_IDLE;
            end
            default: begin
                n_state = crse_pkg::C_IDLE;
            end
        endcase
    end

    // shared multiplier: low half of h (unsigned) then high half (signed)
    always_comb begin
        if (r_phase == 2'd0) begin
            mul_a = $signed({1'b0, r_h[crse_pkg::LO_W-1:0]});
        end else begin
            mul_a = $signed({r_h[crse_pkg::H_W-1], r_h[crse_pkg::H_W-1:crse_pkg::LO_W]});
        end
        mul_b = $signed({1'b0, r_t});
        mul_p = mul_a * mul_b;

        case (r_step)
            2'd0:    c_sel = r_c2;
            2'd1:    c_sel = r_c1;
            default: c_sel = r_c0;
        endcase

        rnd    = (r_acc + RND_HALF) >>> crse_pkg::FRAC_W;
        h_next = c_sel + rnd[crse_pkg::H_W-1:0];

        half = (r_h + crse_pkg::H_W'(1)) >>> 1;
        if (half > SAT_HI) begin
            sat = SAT_HI[crse_pkg::COORD_W-1:0];
        end else if (half < SAT_LO) begin
            sat = SAT_LO[crse_pkg::COORD_W-1:0];
        end else begin
            sat = half[crse_pkg::COORD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= (r_state == crse_pkg::C_FINAL);
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        case (r_state)
            crse_pkg::C_IDLE: begin
                r_d     <= crse_pkg::D_W'(i_p2) - crse_pkg::D_W'(i_p1);
                r_e     <= crse_pkg::D_W'(i_p3) - crse_pkg::D_W'(i_p0);
                r_f     <= crse_pkg::D_W'(i_p0) - crse_pkg::D_W'(i_p1);
                r_c1    <= crse_pkg::H_W'(i_p2) - crse_pkg::H_W'(i_p0);
                r_c0    <= crse_pkg::H_W'(i_p1) <<< 1;
                r_t     <= i_req.t;
                r_phase <= 2'd0;
                r_step  <= 2'd0;
            end
            crse_pkg::C_COEF: begin
                // c3 = e - 3d, c2 = f - e + 4d
                r_h  <= crse_pkg::H_W'(r_e) - crse_pkg::H_W'(r_d)
                        - (crse_pkg::H_W'(r_d) <<< 1);
                r_c2 <= crse_pkg::H_W'(r_f) - crse_pkg::H_W'(r_e)
                        + (crse_pkg::H_W'(r_d) <<< 2);
            end
            crse_pkg::C_MUL: begin
                r_phase <= r_phase + 2'd1;
                case (r_phase)
                    2'd1: r_acc <= crse_pkg::ACC_W'(r_prod);
                    2'd2: r_acc <= r_acc + (crse_pkg::ACC_W'(r_prod) <<< crse_pkg::LO_W);
                    2'd3: begin
                        r_h    <= h_next;
                        r_step <= r_step + 2'd1;
                    end
                    default: ;
                endcase
            end
            crse_pkg::C_FINAL: begin
                r_val <= sat;
            end
            default: ;
        endcase
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.value = r_val;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> r_state == crse_pkg::C_IDLE)
        else $error("cubic started while busy");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("cubic done longer than one cycle");

endmodule

FILE: hdl/catmull_rom_spline_eval.sv
// Catmull-Rom spline evaluator top level: command sequencer, point tables,
// config register. Depends on crse_pkg, crse_ram, crse_cubic.
//
// Usage: a transaction is taken when start is high and busy is low. Add and
// clear transactions, evaluate with fewer than three points, and unknown
// operations are handled while idle: o_done pulses on the next cycle and busy
// stays low. An evaluate whose index is clamped reads one table row and then
// returns to idle. A full evaluate reads four rows and then runs six cubics
// (x, y, z at t and at t + step) one after another on the shared multiplier.
// busy is high for the whole evaluate. o_done is high for one cycle with each
// result, which stays on the o_ ports until the next transaction is taken;
// the receiver cannot stall, so nothing is held back. o_point_count always
// shows the current point count. Reset empties the table (contents are left
// as they are) and sets the look-ahead step to its default. The step register
// sits at APB byte address 0; the user must see that it is written only while
// the block is idle, as the block itself does not enforce this.
module catmull_rom_spline_eval (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    output logic                                  o_done,
    input  logic [1:0]                            i_operation,
    input  logic signed [crse_pkg::COORD_W-1:0]   i_point_x,
    input  logic signed [crse_pkg::COORD_W-1:0]   i_point_y,
    input  logic signed [crse_pkg::COORD_W-1:0]   i_point_z,
    input  logic signed [crse_pkg::IDX_W-1:0]     i_start_index,
    input  logic [crse_pkg::TR_W-1:0]             i_time_rate,
    output logic signed [crse_pkg::COORD_W-1:0]   o_pos_x,
    output logic signed [crse_pkg::COORD_W-1:0]   o_pos_y,
    output logic signed [crse_pkg::COORD_W-1:0]   o_pos_z,
    output logic signed [crse_pkg::COORD_W-1:0]   o_ahead_x,
    output logic signed [crse_pkg::COORD_W-1:0]   o_ahead_y,
    output logic signed [crse_pkg::COORD_W-1:0]   o_ahead_z,
    output logic [crse_pkg::PC_W-1:0]             o_point_count,
    output logic [1:0]                            o_status,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [crse_pkg::PADDR_W-1:0]          paddr,
    input  logic [crse_pkg::PDATA_W-1:0]          pwdata,
    output logic [crse_pkg::PDATA_W-1:0]          prdata,
    output logic                                  pready
);

    crse_pkg::t_state r_state, n_state;

    logic [crse_pkg::CNT_W-1:0]          r_count;
    logic [crse_pkg::STEP_W-1:0]         r_step;
    logic                                r_done;
    logic [crse_pkg::T_W-1:0]            r_t, r_ta;
    logic [crse_pkg::ADDR_W-1:0]         r_base;
    logic                                r_fixed;
    logic [2:0]                          r_cnt;
    logic [1:0]                          r_axis;
    logic                                r_second;
    logic signed [crse_pkg::COORD_W-1:0] r_pts [3][4];
    logic signed [crse_pkg::COORD_W-1:0] r_res [6];
    crse_pkg::t_status                   r_status;

    logic                                accept;
    crse_pkg::t_op                       op;
    logic                                full, few, last;
    logic signed [crse_pkg::CMP_W-1:0]   idx_s, last_s, base_w;
    logic                                ge_last, lt_one;
    logic                                ram_we;
    logic [crse_pkg::ADDR_W-1:0]         ram_raddr;
    logic [crse_pkg::COORD_W-1:0]        dout_x, dout_y, dout_z;
    logic [1:0]                          slot;
    logic [2:0]                          res_idx;
    logic                                cfg_we;
    logic [crse_pkg::CNT_W+crse_pkg::PC_W-1:0] cnt_ext;
    crse_pkg::t_cub_req                  cub_req;
    crse_pkg::t_cub_rsp                  cub_rsp;
    logic signed [crse_pkg::COORD_W-1:0] cp0, cp1, cp2, cp3;

    assign busy   = (r_state != crse_pkg::S_IDLE);
    assign accept = start && !busy;
    assign op     = crse_pkg::t_op'(i_operation);
    assign full   = (r_count >= crse_pkg::CNT_W'(crse_pkg::MAX_POINTS));
    assign few    = (r_count < crse_pkg::CNT_W'(3));
    assign last   = r_second && (r_axis == 2'd2);
    assign ram_we = accept && (op == crse_pkg::OP_ADD) && !full;
    assign ram_raddr = r_base + crse_pkg::ADDR_W'(r_cnt[1:0]);
    assign slot    = 2'(r_cnt - 3'd1);
    assign res_idx = r_second ? (3'(r_axis) + 3'd3) : 3'(r_axis);
    assign cfg_we  = psel && penable && pwrite && pready &&
                     (crse_pkg::t_reg'(paddr[crse_pkg::PADDR_W-1]) == crse_pkg::REG_LOOKAHEAD);

    // segment clamp
    always_comb begin
        idx_s   = crse_pkg::CMP_W'(i_start_index);
        last_s  = $signed(crse_pkg::CMP_W'(r_count) - crse_pkg::CMP_W'(2));
        ge_last = (idx_s >= last_s);
        lt_one  = (idx_s < $signed(crse_pkg::CMP_W'(1)));
        if (ge_last) begin
            base_w = last_s;
        end else if (lt_one) begin
            base_w = $signed(crse_pkg::CMP_W'(1));
        end else begin
            base_w = idx_s - $signed(crse_pkg::CMP_W'(1));
        end
    end

    always_comb begin
        case (r_axis)
            2'd1: begin
                cp0 = r_pts[1][0]; cp1 = r_pts[1][1]; cp2 = r_pts[1][2]; cp3 = r_pts[1][3];
            end
            2'd2: begin
                cp0 = r_pts[2][0]; cp1 = r_pts[2][1]; cp2 = r_pts[2][2]; cp3 = r_pts[2][3];
            end
            default: begin
                cp0 = r_pts[0][0]; cp1 = r_pts[0][1]; cp2 = r_pts[0][2]; cp3 = r_pts[0][3];
            end
        endcase
        cub_req.start = (r_state == crse_pkg::S_CSTART);
        cub_req.t     = r_second ? r_ta : r_t;
    end

    crse_ram #(.WIDTH(crse_pkg::COORD_W), .DEPTH(crse_pkg::MAX_POINTS)) u_ram_x (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[crse_pkg::ADDR_W-1:0]),
        .i_wdata (i_point_x),
        .i_raddr (ram_raddr),
        .o_rdata (dout_x)
    );

    crse_ram #(.WIDTH(crse_pkg::COORD_W), .DEPTH(crse_pkg::MAX_POINTS)) u_ram_y (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[crse_pkg::ADDR_W-1:0]),
        .i_wdata (i_point_y),
        .i_raddr (ram_raddr),
        .o_rdata (dout_y)
    );

    crse_ram #(.WIDTH(crse_pkg::COORD_W), .DEPTH(crse_pkg::MAX_POINTS)) u_ram_z (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[crse_pkg::ADDR_W-1:0]),
        .i_wdata (i_point_z),
        .i_raddr (ram_raddr),
        .o_rdata (dout_z)
    );

    crse_cubic u_cubic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (cub_req),
        .i_p0    (cp0),
        .i_p1    (cp1),
        .i_p2    (cp2),
        .i_p3    (cp3),
        .o_rsp   (cub_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= crse_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            crse_pkg::S_IDLE: begin
                if (accept && op == crse_pkg::OP_EVAL && !few) begin
                    n_state = crse_pkg::S_FETCH;
                end
            end
            crse_pkg::S_FETCH: begin
                if (r_fixed && r_cnt == 3'd1) begin
                    n_state = crse_pkg::S_IDLE;
                end else if (r_cnt == 3'd4) begin
                    n_state = crse_pkg::S_CSTART;
                end
            end
            crse_pkg::S_CSTART: begin
                n_state = crse_pkg::S_CWAIT;
            end
            crse_pkg::S_CWAIT: begin
                if (cub_rsp.done) begin
                    n_state = last ? crse_pkg::S_IDLE : crse_pkg::S_CSTART;
                end
            end
            default: begin
                n_state = crse_pkg::S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_step  <= crse_pkg::STEP_RESET;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (cfg_we) begin
                r_step <= pwdata[crse_pkg::STEP_W-1:0];
            end
            case (r_state)
                crse_pkg::S_IDLE: begin
                    if (accept) begin
                        unique case (op)
                            crse_pkg::OP_ADD: begin
                                if (!full) begin
                                    r_count <= r_count + crse_pkg::CNT_W'(1);
                                end
                                r_done <= 1'b1;
                            end
                            crse_pkg::OP_CLEAR: begin
                                r_count <= '0;
                                r_done  <= 1'b1;
                            end
                            crse_pkg::OP_EVAL: begin
                                r_done <= few;
                            end
                            default: begin
                                r_done <= 1'b1;
                            end
                        endcase
                    end
                end
                crse_pkg::S_FETCH: begin
                    r_done <= r_fixed && (r_cnt == 3'd1);
                end
                crse_pkg::S_CWAIT: begin
                    r_done <= cub_rsp.done && last;
                end
                default: ;
            endcase
        end
    end

    // transaction payload
    always_ff @(posedge i_clk) begin
        case (r_state)
            crse_pkg::S_IDLE: begin
                if (accept) begin
                    r_t      <= crse_pkg::T_W'(i_time_rate);
                    r_ta     <= crse_pkg::T_W'(i_time_rate) + crse_pkg::T_W'(r_step);
                    r_base   <= base_w[crse_pkg::ADDR_W-1:0];
                    r_fixed  <= ge_last || lt_one;
                    r_cnt    <= 3'd0;
                    r_axis   <= 2'd0;
                    r_second <= 1'b0;
                    for (int k = 0; k < 6; k++) begin
                        r_res[k] <= '0;
                    end
                    if (op == crse_pkg::OP_ADD && full) begin
                        r_status <= crse_pkg::ST_FULL;
                    end else if (op == crse_pkg::OP_EVAL && few) begin
                        r_status <= crse_pkg::ST_FEW;
                    end else begin
                        r_status <= crse_pkg::ST_OK;
                    end
                end
            end
            crse_pkg::S_FETCH: begin
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt != 3'd0) begin
                    r_pts[0][slot] <= dout_x;
                    r_pts[1][slot] <= dout_y;
                    r_pts[2][slot] <= dout_z;
                end
                if (r_fixed && r_cnt == 3'd1) begin
                    r_res[0] <= dout_x;
                    r_res[1] <= dout_y;
                    r_res[2] <= dout_z;
                    r_res[3] <= dout_x;
                    r_res[4] <= dout_y;
                    r_res[5] <= dout_z;
                end
            end
            crse_pkg::S_CWAIT: begin
                if (cub_rsp.done) begin
                    r_res[res_idx] <= $signed(cub_rsp.value);
                    if (r_axis == 2'd2) begin
                        r_axis   <= 2'd0;
                        r_second <= 1'b1;
                    end else begin
                        r_axis <= r_axis + 2'd1;
                    end
                end
            end
            default: ;
        endcase
    end

    assign cnt_ext       = (crse_pkg::CNT_W + crse_pkg::PC_W)'(r_count);
    assign o_point_count = cnt_ext[crse_pkg::PC_W-1:0];
    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_pos_x       = r_res[0];
    assign o_pos_y       = r_res[1];
    assign o_pos_z       = r_res[2];
    assign o_ahead_x     = r_res[3];
    assign o_ahead_y     = r_res[4];
    assign o_ahead_z     = r_res[5];

    assign pready = 1'b1;
    assign prdata = (crse_pkg::t_reg'(paddr[crse_pkg::PADDR_W-1]) == crse_pkg::REG_LOOKAHEAD) ?
                    crse_pkg::PDATA_W'(r_step) : '0;

    a_done_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(accept || r_state != crse_pkg::S_IDLE))
        else $error("result without a transaction");

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= crse_pkg::CNT_W'(crse_pkg::MAX_POINTS))
        else $error("point count above table size");

    a_count_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_count != $past(r_count)) |-> $past(accept))
        else $error("point count changed without a transaction");

endmodule

FILE: tb/catmull_rom_spline_eval_test.sv
// Self-checking testbench for catmull_rom_spline_eval: point table, clamping, cubic evaluation
// and the look-ahead step register, checked against an in-bench predictor.
// Depends on crse_pkg and the catmull_rom_spline_eval RTL only.
module catmull_rom_spline_eval_test;

    localparam logic [1:0] OP_RESERVED = 2'd3;
    localparam logic [crse_pkg::PADDR_W-1:0] STEP_ADDR =
        crse_pkg::PADDR_W'(4 * crse_pkg::REG_LOOKAHEAD);
    localparam longint COORD_MAX = 64'sd2147483647;
    localparam longint COORD_MIN = -64'sd2147483648;
    localparam int REPORT_CAP = 40;

    typedef struct packed {
        logic [1:0]                   op;
        logic [crse_pkg::COORD_W-1:0] x;
        logic [crse_pkg::COORD_W-1:0] y;
        logic [crse_pkg::COORD_W-1:0] z;
        logic [crse_pkg::IDX_W-1:0]   idx;
        logic [crse_pkg::TR_W-1:0]    t;
    } t_spline_cmd;

    // coord: pos x/y/z in 0..2, look-ahead x/y/z in 3..5
    typedef struct packed {
        logic [5:0][crse_pkg::COORD_W-1:0] coord;
        logic [crse_pkg::PC_W-1:0]         count;
        logic [1:0]                        status;
    } t_spline_result;

    logic                                 i_clk = 1'b0;
    logic                                 i_rst_n;
    logic                                 start = 1'b0;
    logic                                 busy;
    logic                                 o_done;
    logic [1:0]                           i_operation = '0;
    logic signed [crse_pkg::COORD_W-1:0]  i_point_x = '0;
    logic signed [crse_pkg::COORD_W-1:0]  i_point_y = '0;
    logic signed [crse_pkg::COORD_W-1:0]  i_point_z = '0;
    logic signed [crse_pkg::IDX_W-1:0]    i_start_index = '0;
    logic [crse_pkg::TR_W-1:0]            i_time_rate = '0;
    logic signed [crse_pkg::COORD_W-1:0]  o_pos_x, o_pos_y, o_pos_z;
    logic signed [crse_pkg::COORD_W-1:0]  o_ahead_x, o_ahead_y, o_ahead_z;
    logic [crse_pkg::PC_W-1:0]            o_point_count;
    logic [1:0]                           o_status;
    logic                                 psel, penable, pwrite;
    logic [crse_pkg::PADDR_W-1:0]         paddr;
    logic [crse_pkg::PDATA_W-1:0]         pwdata;
    logic [crse_pkg::PDATA_W-1:0]         prdata;
    logic                                 pready;

    catmull_rom_spline_eval dut (.*);

    always #5 i_clk = ~i_clk;

    // predictor state
    logic signed [crse_pkg::COORD_W-1:0] pts [3][crse_pkg::MAX_POINTS];
    int                                  stored_points = 0;
    logic [crse_pkg::STEP_W-1:0]         lookahead_q16 = crse_pkg::STEP_RESET;

    t_spline_cmd    cmd_queue [$];
    t_spline_result pending_results [$];
    t_spline_cmd    held_cmd;
    t_spline_result accepted_result;
    t_spline_result want;
    logic [5:0][crse_pkg::COORD_W-1:0] seen;
    string          coord_name [6] = '{"pos_x", "pos_y", "pos_z",
                                       "ahead_x", "ahead_y", "ahead_z"};

    int sender_idle_pct = 0;
    int calm_left = 0;
    int mismatches = 0;
    int planned_count = 0;
    int queued_items = 0;
    int n_added = 0, n_full = 0, n_clear = 0, n_ignored = 0;
    int n_interp = 0, n_clamped = 0, n_few = 0;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] exp_val);
        mismatches++;
        if (mismatches <= REPORT_CAP)
            $display("ERROR @%0t: %s got %h exp %h", $time, what, got, exp_val);
    endtask

    // divide by 2^s, round half up
    function automatic longint half_up_shift(input longint v, input int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic logic [crse_pkg::COORD_W-1:0] catmull_axis(
            input longint p0, input longint p1, input longint p2, input longint p3,
            input longint t);
        longint c0, c1, c2, c3, h;
        c0 = 2 * p1;
        c1 = p2 - p0;
        c2 = 2 * p0 - 5 * p1 + 4 * p2 - p3;
        c3 = -p0 + 3 * p1 - 3 * p2 + p3;
        h = c3;
        h = c2 + half_up_shift(h * t, crse_pkg::FRAC_W);
        h = c1 + half_up_shift(h * t, crse_pkg::FRAC_W);
        h = c0 + half_up_shift(h * t, crse_pkg::FRAC_W);
        h = half_up_shift(h, 1);
        if (h > COORD_MAX) h = COORD_MAX;
        if (h < COORD_MIN) h = COORD_MIN;
        return h[crse_pkg::COORD_W-1:0];
    endfunction

    task automatic apply_command(input t_spline_cmd c, output t_spline_result r);
        int     ix, seg;
        longint t0, t1;
        r = '0;
        r.status = crse_pkg::ST_OK;
        case (c.op)
            crse_pkg::OP_ADD: begin
                if (stored_points < crse_pkg::MAX_POINTS) begin
                    pts[0][stored_points] = c.x;
                    pts[1][stored_points] = c.y;
                    pts[2][stored_points] = c.z;
                    stored_points++;
                    n_added++;
                end else begin
                    r.status = crse_pkg::ST_FULL;
                    n_full++;
                end
            end
            crse_pkg::OP_CLEAR: begin
                stored_points = 0;
                n_clear++;
            end
            crse_pkg::OP_EVAL: begin
                ix = int'($signed(c.idx));
                if (stored_points < 3) begin
                    r.status = crse_pkg::ST_FEW;
                    n_few++;
                end else if (ix >= stored_points - 2 || ix < 1) begin
                    seg = (ix < 1) ? 1 : stored_points - 2;
                    for (int a = 0; a < 3; a++) begin
                        r.coord[a] = pts[a][seg];
                        r.coord[a+3] = pts[a][seg];
                    end
                    n_clamped++;
                end else begin
                    t0 = longint'(c.t);
                    t1 = t0 + longint'(lookahead_q16);
                    for (int a = 0; a < 3; a++) begin
                        r.coord[a] = catmull_axis(pts[a][ix-1], pts[a][ix], pts[a][ix+1],
                                                  pts[a][ix+2], t0);
                        r.coord[a+3] = catmull_axis(pts[a][ix-1], pts[a][ix], pts[a][ix+1],
                                                    pts[a][ix+2], t1);
                    end
                    n_interp++;
                end
            end
            default: n_ignored++;
        endcase
        r.count = crse_pkg::PC_W'(stored_points);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                apply_command(held_cmd, accepted_result);
                pending_results = {pending_results, accepted_result};
            end
            if (calm_left > 0) calm_left--;
            else if ($urandom_range(63) == 0) calm_left = 40;
            if (!start || !busy) begin
                if (cmd_queue.size() > 0 &&
                    (calm_left > 0 || $urandom_range(99) >= sender_idle_pct)) begin
                    held_cmd = cmd_queue.pop_front();
                    start <= 1'b1;
                    i_operation <= held_cmd.op;
                    i_point_x <= held_cmd.x;
                    i_point_y <= held_cmd.y;
                    i_point_z <= held_cmd.z;
                    i_start_index <= held_cmd.idx;
                    i_time_rate <= held_cmd.t;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor: outputs are registered, sampled mid-cycle
    always @(negedge i_clk) begin
        if (i_rst_n && o_done) begin
            seen = {o_ahead_z, o_ahead_y, o_ahead_x, o_pos_z, o_pos_y, o_pos_x};
            if (pending_results.size() == 0) begin
                report_mismatch("result with no transaction pending", 64'(seen[0]), '0);
            end else begin
                want = pending_results.pop_front();
                for (int k = 0; k < 6; k++)
                    if (seen[k] !== want.coord[k])
                        report_mismatch(coord_name[k], 64'(seen[k]), 64'(want.coord[k]));
                if (o_point_count !== want.count)
                    report_mismatch("point_count", 64'(o_point_count), 64'(want.count));
                if (o_status !== want.status)
                    report_mismatch("status", 64'(o_status), 64'(want.status));
            end
        end
    end

    task automatic push_cmd(input logic [1:0] op, input logic [crse_pkg::COORD_W-1:0] x,
                            input logic [crse_pkg::COORD_W-1:0] y,
                            input logic [crse_pkg::COORD_W-1:0] z,
                            input logic [crse_pkg::IDX_W-1:0] idx,
                            input logic [crse_pkg::TR_W-1:0] t);
        t_spline_cmd c;
        c = '{op: op, x: x, y: y, z: z, idx: idx, t: t};
        cmd_queue = {cmd_queue, c};
        if (op != OP_RESERVED) queued_items++;
        if (op == crse_pkg::OP_ADD && planned_count < crse_pkg::MAX_POINTS) planned_count++;
        if (op == crse_pkg::OP_CLEAR) planned_count = 0;
    endtask

    function automatic logic [crse_pkg::COORD_W-1:0] rand_coord();
        if ($urandom_range(7) == 0) return $urandom;
        return $urandom_range(33554431) - 32'd16777216;
    endfunction

    function automatic logic [crse_pkg::TR_W-1:0] rand_param();
        int r;
        r = $urandom_range(9);
        if (r == 0) return '0;
        if (r == 1) return crse_pkg::TR_W'(65536);
        if (r < 4) return crse_pkg::TR_W'($urandom_range(131071));
        return crse_pkg::TR_W'($urandom_range(65536));
    endfunction

    function automatic logic [crse_pkg::IDX_W-1:0] rand_segment();
        if (planned_count >= 4 && $urandom_range(4) != 0)
            return crse_pkg::IDX_W'($urandom_range(planned_count - 3, 1));
        return crse_pkg::IDX_W'($urandom_range(511));
    endfunction

    task automatic push_random(input logic [1:0] op, input logic [crse_pkg::IDX_W-1:0] idx);
        push_cmd(op, rand_coord(), rand_coord(), rand_coord(), idx, rand_param());
    endtask

    task automatic queue_directed();
        logic [crse_pkg::COORD_W-1:0] hi, lo;
        hi = 32'h7FFF_FFFF;
        lo = 32'h8000_0000;
        push_cmd(crse_pkg::OP_EVAL, '0, '0, '0, 9'd1, '0);
        push_cmd(crse_pkg::OP_ADD, hi, lo, '0, '0, '0);
        push_cmd(crse_pkg::OP_EVAL, '0, '0, '0, 9'd1, '0);
        push_cmd(crse_pkg::OP_ADD, lo, hi, '1, '1, '1);
        push_cmd(crse_pkg::OP_EVAL, '0, '0, '0, 9'd1, '0);
        push_cmd(crse_pkg::OP_ADD, hi, hi, lo, '0, '0);
        push_cmd(crse_pkg::OP_ADD, lo, lo, hi, '0, '0);
        push_cmd(crse_pkg::OP_EVAL, '0, '0, '0, 9'd1, '0);
        push_cmd(crse_pkg::OP_EVAL, '0, '0, '0, 9'd1, crse_pkg::TR_W'(65536));
        push_cmd(crse_pkg::OP_EVAL, '0, '0, '0, 9'd1, '1);
        push_cmd(crse_pkg::OP_EVAL, '0, '0, '0, 9'd0, crse_pkg::TR_W'(32768));
        push_cmd(crse_pkg::OP_EVAL, '0, '0, '0, 9'h100, crse_pkg::TR_W'(32768));
        push_cmd(crse_pkg::OP_EVAL, '0, '0, '0, 9'd2, crse_pkg::TR_W'(32768));
        push_cmd(crse_pkg::OP_EVAL, '0, '0, '0, 9'd255, crse_pkg::TR_W'(32768));
        push_cmd(OP_RESERVED, hi, hi, hi, '1, '1);
        push_cmd(crse_pkg::OP_CLEAR, '0, '0, '0, '0, '0);
        push_cmd(crse_pkg::OP_EVAL, '0, '0, '0, 9'd1, '0);
        for (int k = 0; k < 4; k++) push_random(crse_pkg::OP_ADD, '0);
        push_cmd(crse_pkg::OP_EVAL, '0, '0, '0, 9'd1, crse_pkg::TR_W'(32768));
    endtask

    task automatic queue_random_traffic(input int n, input bit with_fill);
        int first, pts_to_add;
        first = queued_items;
        while (queued_items - first < n) begin
            if (with_fill && queued_items - first >= n / 2) begin
                with_fill = 0;
                push_random(crse_pkg::OP_CLEAR, '0);
                for (int k = 0; k < crse_pkg::MAX_POINTS + 3; k++)
                    push_random(crse_pkg::OP_ADD, '0);
                for (int k = 0; k < 8; k++)
                    push_random(crse_pkg::OP_EVAL,
                                crse_pkg::IDX_W'($urandom_range(255, 248)));
            end else if ($urandom_range(99) < 70) begin
                if (planned_count < 4 || planned_count > 40 || $urandom_range(5) == 0) begin
                    push_random(crse_pkg::OP_CLEAR, '0);
                    pts_to_add = ($urandom_range(9) == 0) ? $urandom_range(3, 1)
                                                          : $urandom_range(12, 4);
                    for (int k = 0; k < pts_to_add; k++) push_random(crse_pkg::OP_ADD, '0);
                end
                repeat ($urandom_range(6, 2)) push_random(crse_pkg::OP_EVAL, rand_segment());
            end else begin
                case ($urandom_range(3))
                    0: push_random(OP_RESERVED, crse_pkg::IDX_W'($urandom_range(511)));
                    1: push_random(crse_pkg::OP_EVAL, crse_pkg::IDX_W'($urandom_range(511)));
                    2: push_random(crse_pkg::OP_ADD, crse_pkg::IDX_W'($urandom_range(511)));
                    default: push_random(crse_pkg::OP_CLEAR,
                                         crse_pkg::IDX_W'($urandom_range(511)));
                endcase
            end
        end
    endtask

    // block idle: everything sent and every result back, then a short tail
    task automatic wait_quiet(input int tail);
        int guard;
        guard = 0;
        while (cmd_queue.size() != 0 || start) @(negedge i_clk);
        while (pending_results.size() != 0 && guard < 20000) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (tail) @(negedge i_clk);
    endtask

    task automatic set_lookahead(input logic [crse_pkg::STEP_W-1:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= STEP_ADDR;
        pwdata <= crse_pkg::PDATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        lookahead_q16 = value;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge i_clk);
    endtask

    initial begin
        #(30_000_000);
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        queue_directed();
        wait_quiet(8);

        set_lookahead('0);
        sender_idle_pct = 0;
        queue_random_traffic(425, 0);
        wait_quiet(8);

        set_lookahead('1);
        sender_idle_pct = 67;
        queue_random_traffic(425, 1);
        wait_quiet(8);

        set_lookahead(crse_pkg::STEP_W'($urandom));
        sender_idle_pct = 0;
        queue_random_traffic(425, 0);
        wait_quiet(8);

        set_lookahead(crse_pkg::STEP_W'($urandom_range(2000)));
        sender_idle_pct = 28;
        queue_random_traffic(425, 1);
        wait_quiet(120);

        if (pending_results.size() != 0)
            report_mismatch("results never arrived", 64'(pending_results.size()), '0);

        $display("Covered %0d point adds, %0d refused on a full table, %0d clears,",
                 n_added, n_full, n_clear);
        $display("%0d ignored ops; evaluates: %0d interpolated, %0d clamped, %0d short.",
                 n_ignored, n_interp, n_clamped, n_few);
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule

FILE: sim.f
hdl/crse_pkg.sv
hdl/crse_ram.sv
hdl/crse_cubic.sv
hdl/catmull_rom_spline_eval.sv
tb/catmull_rom_spline_eval_test.sv
